### rtl/vsma_pkg.sv
// package for the valid-sample moving average block
// widths, window depth, status codes and shared types; no dependencies
`default_nettype none

package vsma_pkg;

    localparam int WINDOW_DEPTH = 6;

    localparam int DIST_W   = 13;
    localparam int STATUS_W = 4;
    localparam int OUT_W    = 14;
    localparam int VCOUNT_W = 3;

    localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = DIST_W + COUNT_W;
    localparam int ITER_W  = $clog2(SUM_W + 1);

    localparam logic [DIST_W-1:0]   MAX_DISTANCE_RESET = DIST_W'(2000);
    localparam logic [STATUS_W-1:0] STATUS_PHASE_FAIL  = STATUS_W'(4);

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] dist_mm;
    } entry_t;

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

### rtl/vsma_window.sv
// circular sample window with per-entry valid bits
// depends on vsma_pkg
`default_nettype none

module vsma_window
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [vsma_pkg::IDX_W-1:0] wr_idx,
    input  wire vsma_pkg::entry_t          wr_entry,
    input  wire logic [vsma_pkg::IDX_W-1:0] rd_idx,
    output vsma_pkg::entry_t               rd_entry
);

    logic [vsma_pkg::WINDOW_DEPTH-1:0]  valid_reg;
    logic [vsma_pkg::DIST_W-1:0]        dist_reg [vsma_pkg::WINDOW_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= wr_entry.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dist_reg[wr_idx] <= wr_entry.dist_mm;
        end
    end

    assign rd_entry.valid   = valid_reg[rd_idx];
    assign rd_entry.dist_mm = dist_reg[rd_idx];

endmodule

`default_nettype wire

### rtl/vsma_divider.sv
// restoring divider, one quotient bit per cycle
// depends on vsma_pkg
`default_nettype none

module vsma_divider
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire vsma_pkg::div_req_t        req,
    output logic                           done,
    output logic [vsma_pkg::SUM_W-1:0]     quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [vsma_pkg::ITER_W-1:0]       iter_reg;
    logic [vsma_pkg::SUM_W-1:0]        quot_reg;
    logic [vsma_pkg::COUNT_W-1:0]      rem_reg;
    logic [vsma_pkg::COUNT_W-1:0]      divisor_reg;

    logic [vsma_pkg::COUNT_W:0]        trial;
    logic                              fits;
    logic [vsma_pkg::COUNT_W-1:0]      rem_next;

    always_comb
    begin
        trial    = {rem_reg, quot_reg[vsma_pkg::SUM_W-1]};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_next = fits ? vsma_pkg::COUNT_W'(trial - {1'b0, divisor_reg})
                        : vsma_pkg::COUNT_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= vsma_pkg::ITER_W'(vsma_pkg::SUM_W);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == vsma_pkg::ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[vsma_pkg::SUM_W-2:0], fits};
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

### rtl/valid_sample_moving_average_top.sv
// Moving average of range samples with rejection of invalid samples. Each
// transaction writes one sample into a circular window of WINDOW_DEPTH entries
// and returns the sample (-1 when rejected), the truncated mean of the valid
// entries (-1 when none) and the valid count. The window is summed one entry
// per cycle through a single adder, then divided by the valid count in a
// restoring divider that yields one bit per cycle; the divide is skipped when
// no entry is valid, and the result waits while out_stall holds it. in_stall
// is high while a transaction is in work. The window is empty after reset
// with no sweep.
// depends on vsma_pkg, vsma_window, vsma_divider
`default_nettype none

module valid_sample_moving_average_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [vsma_pkg::DIST_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [vsma_pkg::DIST_W-1:0]   distance_mm,
    input  wire logic [vsma_pkg::STATUS_W-1:0] range_status,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [vsma_pkg::OUT_W-1:0]  filtered_sample,
    output logic signed [vsma_pkg::OUT_W-1:0]  window_mean,
    output logic [vsma_pkg::VCOUNT_W-1:0]      valid_count
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic [vsma_pkg::DIST_W-1:0]        max_dist_reg;
    logic [vsma_pkg::IDX_W-1:0]         wr_idx_reg;
    logic [vsma_pkg::IDX_W-1:0]         sweep_idx_reg;
    logic [vsma_pkg::SUM_W-1:0]         sum_reg;
    logic [vsma_pkg::SUM_W-1:0]         sum_next;
    logic [vsma_pkg::COUNT_W-1:0]       cnt_reg;
    logic [vsma_pkg::COUNT_W-1:0]       cnt_next;
    logic signed [vsma_pkg::OUT_W-1:0]  filt_reg;
    logic signed [vsma_pkg::OUT_W-1:0]  mean_reg;
    logic                               out_valid_reg;
    logic signed [vsma_pkg::OUT_W-1:0]  out_filt_reg;
    logic signed [vsma_pkg::OUT_W-1:0]  out_mean_reg;
    logic [vsma_pkg::VCOUNT_W-1:0]      out_count_reg;

    logic                               accept;
    logic                               sample_ok;
    logic                               sweep_last;
    logic                               out_free;
    vsma_pkg::entry_t                   wr_entry;
    vsma_pkg::entry_t                   rd_entry;
    vsma_pkg::div_req_t                 div_req;
    logic                               div_done;
    logic [vsma_pkg::SUM_W-1:0]         div_quot;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign sample_ok = (range_status != vsma_pkg::STATUS_PHASE_FAIL)
                       && (distance_mm <= max_dist_reg);
    assign sweep_last = (sweep_idx_reg == vsma_pkg::IDX_W'(vsma_pkg::WINDOW_DEPTH - 1));
    assign out_free   = !out_valid_reg || !out_stall;

    assign wr_entry.valid   = sample_ok;
    assign wr_entry.dist_mm = distance_mm;

    vsma_window u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_idx   (wr_idx_reg),
        .wr_entry (wr_entry),
        .rd_idx   (sweep_idx_reg),
        .rd_entry (rd_entry)
    );

    // one window entry per cycle through the accumulator
    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (rd_entry.valid)
        begin
            sum_next = sum_reg + vsma_pkg::SUM_W'(rd_entry.dist_mm);
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign div_req.start    = (state_reg == S_SUM) && sweep_last && (cnt_next != '0);
    assign div_req.dividend = sum_next;
    assign div_req.divisor  = cnt_next;

    vsma_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (sweep_last)
                begin
                    state_next = (cnt_next != '0) ? S_DIV : S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_dist_reg  <= vsma_pkg::MAX_DISTANCE_RESET;
            wr_idx_reg    <= '0;
            sweep_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                max_dist_reg <= cfg_data;
            end
            if (accept)
            begin
                sweep_idx_reg <= '0;
                wr_idx_reg <= (wr_idx_reg == vsma_pkg::IDX_W'(vsma_pkg::WINDOW_DEPTH - 1))
                              ? '0 : wr_idx_reg + 1'b1;
            end
            else if (state_reg == S_SUM)
            begin
                sweep_idx_reg <= sweep_idx_reg + 1'b1;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            filt_reg <= sample_ok ? signed'({1'b0, distance_mm}) : '1;
        end
        else if (state_reg == S_SUM)
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            if (sweep_last && cnt_next == '0)
            begin
                mean_reg <= '1;
            end
        end
        else if (state_reg == S_DIV && div_done)
        begin
            mean_reg <= signed'(vsma_pkg::OUT_W'(div_quot));
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_filt_reg  <= filt_reg;
            out_mean_reg  <= mean_reg;
            out_count_reg <= vsma_pkg::VCOUNT_W'(cnt_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = out_filt_reg;
    assign window_mean     = out_mean_reg;
    assign valid_count     = out_count_reg;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for valid_sample_moving_average_top: range samples
// and max-distance settings go in; results are checked against a predictor or
// typed table rows; depends on vsma_pkg and the RTL of the block

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 3 + vsma_pkg::WINDOW_DEPTH + vsma_pkg::SUM_W + 8;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int QUIET_ITEMS    = 40;
    localparam int DIRECTED_ROWS  = 21;
    localparam int DIST_TOP       = (1 << vsma_pkg::DIST_W) - 1;

    localparam logic signed [vsma_pkg::OUT_W-1:0] NO_SAMPLE = '1;

    typedef struct packed {
        logic signed [vsma_pkg::OUT_W-1:0] sample;
        logic signed [vsma_pkg::OUT_W-1:0] mean;
        logic [vsma_pkg::VCOUNT_W-1:0]     count;
    } window_result_t;

    typedef struct packed {
        logic [vsma_pkg::DIST_W-1:0]   dist_mm;
        logic [vsma_pkg::STATUS_W-1:0] status;
        logic                          typed;
        window_result_t                want;
    } sample_row_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [vsma_pkg::DIST_W-1:0]          cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [vsma_pkg::DIST_W-1:0]          distance_mm = '0;
    logic [vsma_pkg::STATUS_W-1:0]        range_status = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [vsma_pkg::OUT_W-1:0]    filtered_sample;
    logic signed [vsma_pkg::OUT_W-1:0]    window_mean;
    logic [vsma_pkg::VCOUNT_W-1:0]        valid_count;

    // predictor state
    logic                                 ring_ok [vsma_pkg::WINDOW_DEPTH];
    logic [vsma_pkg::DIST_W-1:0]          ring_dist [vsma_pkg::WINDOW_DEPTH];
    int                                   ring_ptr;
    logic [vsma_pkg::DIST_W-1:0]          max_dist_model;

    window_result_t                       expected_results [$];
    window_result_t                       oldest;
    bit                                   quiet = 1'b0;
    int                                   stall_left = 0;
    int                                   idle_cycles = 0;
    int                                   errors = 0;
    int                                   sent_count = 0;
    int                                   checked_count = 0;
    int                                   rejected_count = 0;
    int                                   cfg_count = 0;
    logic [vsma_pkg::DIST_W-1:0]          cfg_plan [PHASE_COUNT];

    sample_row_t directed_rows [DIRECTED_ROWS] = '{
        '{13'd100,  vsma_pkg::STATUS_PHASE_FAIL, 1'b1, '{NO_SAMPLE, NO_SAMPLE, 3'd0}},
        '{13'd2001, 4'd0,  1'b1, '{NO_SAMPLE, NO_SAMPLE, 3'd0}},
        '{13'd2000, 4'd0,  1'b1, '{14'sd2000, 14'sd2000, 3'd1}},
        '{13'd0,    4'd0,  1'b1, '{14'sd0, 14'sd1000, 3'd2}},
        '{13'd8191, 4'd15, 1'b1, '{NO_SAMPLE, 14'sd1000, 3'd2}},
        '{13'd1999, 4'd1,  1'b0, '0},
        '{13'd1234, 4'd2,  1'b0, '0},
        '{13'd500,  4'd3,  1'b0, '0},
        '{13'd8191, vsma_pkg::STATUS_PHASE_FAIL, 1'b0, '0},
        '{13'd777,  4'd5,  1'b0, '0},
        '{13'd1500, 4'd6,  1'b0, '0},
        '{13'd42,   4'd7,  1'b0, '0},
        '{13'd1000, 4'd8,  1'b0, '0},
        '{13'd2000, 4'd9,  1'b0, '0},
        '{13'd1,    4'd10, 1'b0, '0},
        '{13'd1800, 4'd11, 1'b0, '0},
        '{13'd999,  4'd12, 1'b0, '0},
        '{13'd2000, 4'd13, 1'b0, '0},
        '{13'd3,    4'd14, 1'b0, '0},
        '{13'd4095, 4'd15, 1'b0, '0},
        '{13'd2000, vsma_pkg::STATUS_PHASE_FAIL, 1'b0, '0}
    };

    valid_sample_moving_average_top dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .distance_mm     (distance_mm),
        .range_status    (range_status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .filtered_sample (filtered_sample),
        .window_mean     (window_mean),
        .valid_count     (valid_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [vsma_pkg::DIST_W-1:0] pick_distance();
        int r;
        int near;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5)
        begin
            // around the threshold
            near = int'(max_dist_model) + int'($urandom_range(0, 4)) - 2;
            if (near < 0)
                near = 0;
            if (near > DIST_TOP)
                near = DIST_TOP;
            return vsma_pkg::DIST_W'(near);
        end
        return vsma_pkg::DIST_W'($urandom);
    endfunction

    function automatic window_result_t push_sample(
        input logic [vsma_pkg::DIST_W-1:0] d,
        input logic [vsma_pkg::STATUS_W-1:0] s);
        window_result_t r;
        logic ok;
        int sum;
        int cnt;
        int i;
        ok = (s != vsma_pkg::STATUS_PHASE_FAIL) && (d <= max_dist_model);
        ring_ok[ring_ptr] = ok;
        ring_dist[ring_ptr] = ok ? d : '0;
        ring_ptr = (ring_ptr + 1 < vsma_pkg::WINDOW_DEPTH) ? ring_ptr + 1 : 0;
        sum = 0;
        cnt = 0;
        for (i = 0; i < vsma_pkg::WINDOW_DEPTH; i++)
        begin
            if (ring_ok[i])
            begin
                sum += int'(ring_dist[i]);
                cnt++;
            end
        end
        if (!ok)
            rejected_count++;
        r.sample = ok ? vsma_pkg::OUT_W'({1'b0, d}) : NO_SAMPLE;
        r.mean   = (cnt != 0) ? vsma_pkg::OUT_W'(sum / cnt) : NO_SAMPLE;
        r.count  = vsma_pkg::VCOUNT_W'(cnt);
        return r;
    endfunction

    task automatic send_sample(input logic [vsma_pkg::DIST_W-1:0] d,
                               input logic [vsma_pkg::STATUS_W-1:0] s,
                               input logic typed, input window_result_t want);
        int gap;
        window_result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        distance_mm  <= d;
        range_status <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = push_sample(d, s);
        expected_results.push_back(typed ? want : predicted);
        sent_count++;
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0 || in_stall)
            @(posedge clk);
    endtask

    task automatic write_max_distance(input logic [vsma_pkg::DIST_W-1:0] v);
        drain_block();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        max_dist_model = v;
        cfg_count++;
    endtask

    // result side: random stalls and checking
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no transaction pending: sample %0d mean %0d count %0d",
                           filtered_sample, window_mean, valid_count);
                    errors++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (filtered_sample !== oldest.sample)
                    begin
                        $error("filtered_sample: expected %0d, got %0d",
                               oldest.sample, filtered_sample);
                        errors++;
                    end
                    if (window_mean !== oldest.mean)
                    begin
                        $error("window_mean: expected %0d, got %0d", oldest.mean, window_mean);
                        errors++;
                    end
                    if (valid_count !== oldest.count)
                    begin
                        $error("valid_count: expected %0d, got %0d", oldest.count, valid_count);
                        errors++;
                    end
                    checked_count++;
                end
            end
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= pick_gap();
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int p;
        int n;
        int i;
        logic [vsma_pkg::STATUS_W-1:0] s;
        for (i = 0; i < vsma_pkg::WINDOW_DEPTH; i++)
        begin
            ring_ok[i]   = 1'b0;
            ring_dist[i] = '0;
        end
        ring_ptr       = 0;
        max_dist_model = vsma_pkg::MAX_DISTANCE_RESET;
        cfg_plan = '{'1, '0, vsma_pkg::MAX_DISTANCE_RESET, '0, 13'd1, 13'd8190, '0, 13'd500};
        cfg_plan[3] = vsma_pkg::DIST_W'($urandom);
        cfg_plan[6] = vsma_pkg::DIST_W'($urandom);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DIRECTED_ROWS; n++)
            send_sample(directed_rows[n].dist_mm, directed_rows[n].status,
                        directed_rows[n].typed, directed_rows[n].want);

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            write_max_distance(cfg_plan[p]);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                quiet = (n < QUIET_ITEMS);
                if ($urandom_range(0, 149) == 0)
                    drain_block();
                s = ($urandom_range(0, 3) == 0) ? vsma_pkg::STATUS_PHASE_FAIL
                                                : vsma_pkg::STATUS_W'($urandom);
                send_sample(pick_distance(), s, 1'b0, '0);
            end
            quiet = 1'b0;
        end

        drain_block();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d samples, %0d of them rejected, under %0d max-distance settings",
                 sent_count, rejected_count, cfg_count + 1);
        $display("%0d results compared, %0d mismatches", checked_count, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### valid_sample_moving_average_top.f
rtl/vsma_pkg.sv
rtl/vsma_window.sv
rtl/vsma_divider.sv
rtl/valid_sample_moving_average_top.sv
tb/testbench.sv
